// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define PKI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pki assertion failed");

// next-cycle implication, disabled while reset is high
`define PKI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pki assertion failed");

`endif

// ===== rtl/pki_pkg.sv =====
// types and constants of the particle key interpolator
// no dependencies
`default_nettype none

package pki_pkg;

   typedef enum logic [2:0] {
      CSR_KEY_END_TIME = 3'd0,
      CSR_START_COLOR  = 3'd1,
      CSR_END_COLOR    = 3'd2,
      CSR_START_SCALE  = 3'd3,
      CSR_END_SCALE    = 3'd4,
      CSR_HEAD_CELL    = 3'd5,
      CSR_TAIL_CELL    = 3'd6
   } pki_csr_type;

   localparam int unsigned CSR_DATA_BITS = 48;

   // t = round(raw_t * 0.99 + 0.005), divide by 100 through a reciprocal
   localparam logic [31:0] REMAP_SCALE = 32'd99;
   localparam logic [31:0] REMAP_BIAS  = 32'd50;
   localparam logic [31:0] RECIP_100   = 32'h51EB851F;
   localparam int unsigned RECIP_SHIFT = 37;

   typedef struct packed {
      logic [31:0]        start_color;
      logic [31:0]        end_color;
      logic signed [31:0] start_scale;
      logic signed [31:0] end_scale;
      logic [47:0]        head_setup;
      logic [47:0]        tail_setup;
   } pki_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/pki_div.sv =====
// phase divider: span setup stage then one restoring quotient bit per stage
// no dependencies
`default_nettype none

module pki_div #(
   parameter int unsigned F = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire logic [31:0] age,
   input  wire logic [31:0] prev_end_time,
   input  wire logic [31:0] key_end_time,
   output logic             out_valid,
   output logic [F:0]       out_raw_t
);

   logic        vld_ff  [0:F];
   logic [31:0] rem_ff  [0:F];
   logic [31:0] span_ff [0:F];
   logic [F-1:0] q_ff   [0:F];
   logic        zero_ff [0:F];
   logic        full_ff [0:F];

   logic        pos_in;
   logic [31:0] span_in;
   logic [31:0] num_in;

   always_comb begin
      pos_in  = (key_end_time > prev_end_time) && (age > prev_end_time);
      span_in = key_end_time - prev_end_time;
      num_in  = age - prev_end_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]  <= num_in;
         span_ff[0] <= span_in;
         q_ff[0]    <= '0;
         zero_ff[0] <= !pos_in;
         full_ff[0] <= num_in >= span_in;
      end
   end

   for (genvar i = 1; i <= F; i++) begin : g_step
      logic [32:0]  r2;
      logic         ge;
      logic [32:0]  diff;
      logic [31:0]  rem_in;
      logic [F-1:0] q_in;

      always_comb begin
         r2     = {rem_ff[i-1], 1'b0};
         ge     = r2 >= {1'b0, span_ff[i-1]};
         diff   = r2 - {1'b0, span_ff[i-1]};
         rem_in = ge ? diff[31:0] : r2[31:0];
         q_in   = {q_ff[i-1][F-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         if (adv) begin
            rem_ff[i]  <= rem_in;
            span_ff[i] <= span_ff[i-1];
            q_ff[i]    <= q_in;
            zero_ff[i] <= zero_ff[i-1];
            full_ff[i] <= full_ff[i-1];
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[F];
      if (zero_ff[F]) begin
         out_raw_t = '0;
      end else if (full_ff[F]) begin
         out_raw_t = {1'b1, {F{1'b0}}};
      end else begin
         out_raw_t = {1'b0, q_ff[F]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pki_lerp.sv =====
// remap of the phase and the color, scale and cell interpolation stages
// uses pki_pkg
`default_nettype none

module pki_lerp #(
   parameter int unsigned F  = 16,
   parameter int unsigned CB = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic [F:0]         in_raw_t,
   input  wire pki_pkg::pki_cfg_type cfg,
   output logic                    out_valid,
   output logic [7:0]              alpha_out,
   output logic [7:0]              red_out,
   output logic [7:0]              green_out,
   output logic [7:0]              blue_out,
   output logic signed [31:0]      scale_out,
   output logic [16:0]             head_cell,
   output logic [16:0]             tail_cell
);

   localparam int unsigned CPW = F + 10;
   localparam int unsigned SPW = F + 34;
   localparam int unsigned EPW = F + CB;
   localparam int unsigned DW  = CB + 2;
   localparam int unsigned VW  = CB + F + 3;
   localparam logic [31:0] HALF32 = 32'(1) << (F - 1);
   localparam logic signed [CPW-1:0] HALFC = CPW'(1) <<< (F - 1);

   // stage valid bits
   logic v1_ff, v2_ff, va_ff, vb_ff, vc_ff;

   // remap stages
   logic [31:0]  x_c;
   logic [63:0]  prod_in;
   logic [63:0]  prod_ff;
   logic [F-1:0] t_ff;

   always_comb begin
      x_c     = 32'(32'(in_raw_t) * pki_pkg::REMAP_SCALE) + HALF32 + pki_pkg::REMAP_BIAS;
      prod_in = 64'(x_c) * 64'(pki_pkg::RECIP_100);
   end

   // stage a: products
   logic signed [CPW-1:0] chp_in [0:3];
   logic signed [CPW-1:0] chp_ff [0:3];
   logic signed [SPW-1:0] sp_in;
   logic signed [SPW-1:0] sp_ff;
   logic [F-1:0]          eff_in [0:1];
   logic [F-1:0]          eff_ff [0:1];
   logic [47:0]           setup_c [0:1];
   logic signed [F:0]     t_s;

   always_comb begin
      logic signed [8:0]  cdiff;
      logic signed [32:0] sdiff;
      logic [CB-1:0]      rep;
      logic [EPW-1:0]     ep;
      t_s = $signed({1'b0, t_ff});
      for (int k = 0; k < 4; k++) begin
         cdiff = $signed({1'b0, cfg.end_color[24-8*k +: 8]})
               - $signed({1'b0, cfg.start_color[24-8*k +: 8]});
         chp_in[k] = CPW'(cdiff) * CPW'(t_s);
      end
      sdiff = 33'(cfg.end_scale) - 33'(cfg.start_scale);
      sp_in = SPW'(sdiff) * SPW'(t_s);
      setup_c[0] = cfg.head_setup;
      setup_c[1] = cfg.tail_setup;
      for (int c = 0; c < 2; c++) begin
         rep = setup_c[c][2*CB +: CB];
         if (rep == '0) begin
            rep = CB'(1);
         end
         ep        = EPW'(t_ff) * EPW'(rep);
         eff_in[c] = ep[F-1:0];
      end
   end

   // stage b: channel and scale results, cell products
   logic [7:0]            ch_in  [0:3];
   logic [7:0]            ch_ff  [0:3];
   logic signed [31:0]    sc_in;
   logic signed [31:0]    sc_ff;
   logic signed [VW-1:0]  cp_in  [0:1];
   logic signed [VW-1:0]  cp_ff  [0:1];
   logic [CB:0]           init_in [0:1];
   logic [CB:0]           init_ff [0:1];

   always_comb begin
      logic signed [CPW-1:0] v;
      logic signed [CPW-1:0] r;
      logic signed [SPW-1:0] sh;
      logic signed [34:0]    sum;
      logic [CB-1:0]         cs;
      logic [CB-1:0]         ce;
      logic signed [DW-1:0]  delta;
      for (int k = 0; k < 4; k++) begin
         v = $signed(CPW'({cfg.start_color[24-8*k +: 8], {F{1'b0}}})) + chp_ff[k];
         r = (v + HALFC) >>> F;
         if (v <= 0) begin
            ch_in[k] = 8'd0;
         end else if (r > CPW'(255)) begin
            ch_in[k] = 8'd255;
         end else begin
            ch_in[k] = r[7:0];
         end
      end
      sh  = sp_ff >>> F;
      sum = 35'(cfg.start_scale) + sh[34:0];
      if (sum > 35'sd2147483647) begin
         sc_in = 32'sh7FFFFFFF;
      end else if (sum < -35'sd2147483648) begin
         sc_in = 32'sh80000000;
      end else begin
         sc_in = sum[31:0];
      end
      for (int c = 0; c < 2; c++) begin
         cs = setup_c[c][0 +: CB];
         ce = setup_c[c][CB +: CB];
         if (ce >= cs) begin
            init_in[c] = {1'b0, cs};
            delta      = $signed(DW'(ce)) - $signed(DW'(cs)) + DW'(1);
         end else begin
            init_in[c] = (CB+1)'(cs) + (CB+1)'(1);
            delta      = $signed(DW'(ce)) - $signed(DW'(cs)) - DW'(1);
         end
         cp_in[c] = VW'(delta) * $signed(VW'(eff_ff[c]));
      end
   end

   // stage c: cell results
   logic [16:0] cell_in [0:1];
   logic [7:0]  chc_ff  [0:3];
   logic signed [31:0] scc_ff;
   logic [16:0] cell_ff [0:1];

   always_comb begin
      logic signed [VW-1:0] cv;
      logic [VW-1:0]        csh;
      logic [63:0]          cext;
      for (int c = 0; c < 2; c++) begin
         cv   = $signed(VW'({init_ff[c], {F{1'b0}}})) + cp_ff[c];
         csh  = VW'(cv >>> F);
         cext = 64'(csh);
         if (cv < 0) begin
            cell_in[c] = 17'd0;
         end else begin
            cell_in[c] = cext[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         va_ff <= v2_ff;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      if (adv) begin
         prod_ff <= prod_in;
         t_ff    <= prod_ff[pki_pkg::RECIP_SHIFT +: F];
         for (int k = 0; k < 4; k++) begin
            chp_ff[k] <= chp_in[k];
            ch_ff[k]  <= ch_in[k];
            chc_ff[k] <= ch_ff[k];
         end
         sp_ff  <= sp_in;
         sc_ff  <= sc_in;
         scc_ff <= sc_ff;
         for (int c = 0; c < 2; c++) begin
            eff_ff[c]  <= eff_in[c];
            cp_ff[c]   <= cp_in[c];
            init_ff[c] <= init_in[c];
            cell_ff[c] <= cell_in[c];
         end
      end
   end

   always_comb begin
      out_valid = vc_ff;
      alpha_out = chc_ff[0];
      red_out   = chc_ff[1];
      green_out = chc_ff[2];
      blue_out  = chc_ff[3];
      scale_out = scc_ff;
      head_cell = cell_ff[0];
      tail_cell = cell_ff[1];
   end

endmodule

`default_nettype wire

// ===== rtl/particle_key_interpolator.sv =====
// top level of the particle key interpolator: registers, flow control, stages
// uses pki_pkg, pki_div and pki_lerp
`default_nettype none

// Evaluates one particle key per transfer: phase from age and key times, remapped,
// then four color bytes, a saturated Q16.16 scale and two sprite cell indices.
// One item is accepted every cycle unless the output stalls; items pass the
// divider, which resolves one quotient bit per stage, then the lerp stages.
// When a result waits at the output the whole pipeline holds. The user must write
// registers through the csr port only while no item is in flight; not enforced.
module particle_key_interpolator #(
   parameter int unsigned TIME_FRAC_BITS = 16,
   parameter int unsigned CELL_BITS      = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_age,
   input  wire logic [31:0] req_prev_end_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_alpha_out,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic signed [31:0] rsp_scale_out,
   output logic [16:0]      rsp_head_cell,
   output logic [16:0]      rsp_tail_cell,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [pki_pkg::CSR_DATA_BITS-1:0] csr_data
);

   logic [31:0]          key_end_ff;
   pki_pkg::pki_cfg_type cfg_ff;
   logic                 adv;
   logic                 div_valid;
   logic [TIME_FRAC_BITS:0] div_raw_t;

   assign csr_ready = 1'b1;
   // pipeline moves unless a finished result is held
   assign adv       = rsp_ready || !rsp_valid;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_end_ff <= '0;
         cfg_ff     <= '0;
      end else if (csr_valid) begin
         unique case (pki_pkg::pki_csr_type'(csr_index))
            pki_pkg::CSR_KEY_END_TIME: key_end_ff         <= csr_data[31:0];
            pki_pkg::CSR_START_COLOR:  cfg_ff.start_color <= csr_data[31:0];
            pki_pkg::CSR_END_COLOR:    cfg_ff.end_color   <= csr_data[31:0];
            pki_pkg::CSR_START_SCALE:  cfg_ff.start_scale <= csr_data[31:0];
            pki_pkg::CSR_END_SCALE:    cfg_ff.end_scale   <= csr_data[31:0];
            pki_pkg::CSR_HEAD_CELL:    cfg_ff.head_setup  <= csr_data[47:0];
            pki_pkg::CSR_TAIL_CELL:    cfg_ff.tail_setup  <= csr_data[47:0];
            default: ;
         endcase
      end
   end

   pki_div #(.F(TIME_FRAC_BITS)) u_div (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .age           (req_age),
      .prev_end_time (req_prev_end_time),
      .key_end_time  (key_end_ff),
      .out_valid     (div_valid),
      .out_raw_t     (div_raw_t)
   );

   pki_lerp #(.F(TIME_FRAC_BITS), .CB(CELL_BITS)) u_lerp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_raw_t  (div_raw_t),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .alpha_out (rsp_alpha_out),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out),
      .scale_out (rsp_scale_out),
      .head_cell (rsp_head_cell),
      .tail_cell (rsp_tail_cell)
   );

endmodule

`default_nettype wire

// ===== rtl/pki_checker.sv =====
// port-level checks of the particle key interpolator, bound to the top level
// uses assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pki_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_alpha_out,
   input wire logic [7:0]  rsp_red_out,
   input wire logic [7:0]  rsp_green_out,
   input wire logic [7:0]  rsp_blue_out,
   input wire logic [31:0] rsp_scale_out,
   input wire logic [16:0] rsp_head_cell,
   input wire logic [16:0] rsp_tail_cell
);

   logic [31:0] rsp_color;
   logic [65:0] rsp_rest;

   assign rsp_color = {rsp_alpha_out, rsp_red_out, rsp_green_out, rsp_blue_out};
   assign rsp_rest  = {rsp_scale_out, rsp_head_cell, rsp_tail_cell};

   // a held result keeps valid
   `PKI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // a held result keeps every field
   `PKI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({rsp_color, rsp_rest}))
   // input stalls whenever the output stalls
   `PKI_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // nothing comes out right after reset
   `PKI_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind particle_key_interpolator pki_checker u_pki_checker (.*);

`default_nettype wire
